@@ rtl/core/rpht_pkg.sv @@
package rpht_pkg;

    localparam int BAR_CELLS = 32;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int ADDR_W   = 48;
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int TDB_W    = 6;
    localparam int BAR_W    = 9;
    localparam int COUNT_W  = 32;
    localparam int SILENT_W = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 88;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 8'h81;

    // x / 1000 == (x * DIV1000_MUL) >> DIV1000_SHIFT for all 32-bit x
    localparam logic [28:0] DIV1000_MUL   = 29'd274877907;
    localparam int          DIV1000_SHIFT = 38;
    localparam int          PROD_W        = TIME_W + 29;

    localparam int BAR_SPAN = BAR_CELLS * 8;
    localparam logic [BAR_W-1:0] BAR_FULL = (BAR_SPAN > 511) ? 9'd511 : BAR_W'(BAR_SPAN);

    typedef enum logic {
        OP_ADVERT = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic {
        KIND_SIGNAL  = 1'b0,
        KIND_DROPOUT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        TREND_NONE    = 2'd0,
        TREND_CLOSER  = 2'd1,
        TREND_FARTHER = 2'd2
    } t_trend;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUNT_ENABLE    = 3'd0,
        CFG_TARGET_ADDRESS = 3'd1,
        CFG_REPORT_INTV    = 3'd2,
        CFG_DROPOUT        = 3'd3,
        CFG_DROPOUT_REPEAT = 3'd4,
        CFG_TREND_DB       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              hunt_enable;
        logic [ADDR_W-1:0] target_address;
        logic [MS_W-1:0]   report_interval_ms;
        logic [MS_W-1:0]   dropout_ms;
        logic [MS_W-1:0]   dropout_repeat_ms;
        logic [TDB_W-1:0]  trend_db;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hunt_enable:        1'b0,
        target_address:     48'd0,
        report_interval_ms: 16'd250,
        dropout_ms:         16'd4000,
        dropout_repeat_ms:  16'd3000,
        trend_db:           6'd3
    };

    typedef struct packed {
        t_op               op;
        logic [LEVEL_W-1:0] rssi;
        logic [TIME_W-1:0] now_ms;
    } t_qitem;

    typedef struct packed {
        t_kind               kind;
        logic [LEVEL_W-1:0]  shown;
        logic [LEVEL_W-1:0]  peak;
        t_trend              trend;
        logic [COUNT_W-1:0]  count;
        logic [TIME_W-1:0]   silent;
    } t_rpt;

    typedef logic [BAR_W-1:0] t_bar_lut [256];

    localparam longint unsigned TENTH_POW_Q24 [10] = '{
        64'd16777216, 64'd21121264, 64'd26590095, 64'd33474947, 64'd42142461,
        64'd53054215, 64'd66791300, 64'd84085265, 64'd105857077, 64'd133266164
    };

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_bar_lut build_bar_lut();
        t_bar_lut          lut;
        longint unsigned   s;
        longint unsigned   den;
        longint unsigned   scale;
        longint unsigned   p;
        longint unsigned   num;
        longint unsigned   r;
        int                v;
        int                e;
        int                j;
        int                m;
        s   = longint'(BAR_SPAN);
        den = longint'(150) << 24;
        for (int k = 0; k < 256; k++) begin
            v = (k >= 128) ? k - 256 : k;
            if (v <= -95) begin
                r = 0;
            end else if (v >= -20) begin
                r = s;
            end else begin
                e = v + 100;
                j = 0;
                m = e;
                while (m >= 10) begin
                    m = m - 10;
                    j = j + 1;
                end
                scale = 1;
                for (int i = 0; i < j; i++) begin
                    scale = scale * 10;
                end
                p   = div_u64(TENTH_POW_Q24[m] * scale + 64'd50000000, 64'd100000000);
                num = s * (75 * p + (longint'(v + 95) << 24));
                r   = div_u64(num + (den >> 1), den);
            end
            if (r > 511) begin
                r = 511;
            end
            lut[k] = BAR_W'(r);
        end
        return lut;
    endfunction

    localparam t_bar_lut BAR_LUT = build_bar_lut();

endpackage

@@ rtl/core/rpht_front.sv @@
module rpht_front (
    input  logic                                   i_s_tvalid,
    input  logic [rpht_pkg::S_DATA_W-1:0]          i_s_tdata,  // device_address, rssi, now_ms
    input  logic [0:0]                             i_s_tuser,  // op
    input  rpht_pkg::t_cfg                         i_cfg,
    input  logic                                   i_q_full,
    output logic                                   o_s_tready,
    output logic                                   o_push,
    output rpht_pkg::t_qitem                       o_item
);

    logic [rpht_pkg::ADDR_W-1:0] addr;
    logic                        is_tick;
    logic                        keep;

    assign addr    = i_s_tdata[rpht_pkg::ADDR_W-1:0];
    assign is_tick = (rpht_pkg::t_op'(i_s_tuser[0]) == rpht_pkg::OP_TICK);

    // drop anything that cannot touch state
    assign keep = i_cfg.hunt_enable && (is_tick || (addr == i_cfg.target_address));

    assign o_s_tready    = !i_q_full;
    assign o_push        = i_s_tvalid && o_s_tready && keep;
    assign o_item.op     = rpht_pkg::t_op'(i_s_tuser[0]);
    assign o_item.rssi   = i_s_tdata[55:48];
    assign o_item.now_ms = i_s_tdata[87:56];

endmodule

@@ rtl/core/rpht_queue.sv @@
module rpht_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rpht_pkg::t_qitem i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output rpht_pkg::t_qitem o_item
);

    rpht_pkg::t_qitem                r_mem [rpht_pkg::QDEPTH];
    logic [rpht_pkg::QPTR_W-1:0]     r_wptr;
    logic [rpht_pkg::QPTR_W-1:0]     r_rptr;
    logic [rpht_pkg::QCNT_W-1:0]     r_count;
    logic                            do_pop;

    function automatic logic [rpht_pkg::QPTR_W-1:0] ptr_inc(
        input logic [rpht_pkg::QPTR_W-1:0] p
    );
        if (p == rpht_pkg::QPTR_W'(rpht_pkg::QDEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // no input transfer while reset is held
    assign o_full  = !i_rst_n || (r_count == rpht_pkg::QCNT_W'(rpht_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/rpht_exec.sv @@
module rpht_exec (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rpht_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  rpht_pkg::t_qitem i_q_item,
    output logic             o_q_pop,
    input  logic             i_rpt_ready,
    output logic             o_rpt_valid,
    output rpht_pkg::t_rpt   o_rpt
);

    logic signed [7:0]  r_peak,  n_peak;
    logic signed [7:0]  r_shown, n_shown;
    logic signed [7:0]  r_window, n_window;
    logic [31:0]        r_count, n_count;
    logic [31:0]        r_last_report, n_last_report;
    logic [31:0]        r_last_seen, n_last_seen;
    logic               r_rpt_valid;
    rpht_pkg::t_rpt     r_rpt, n_rpt;

    logic               fire;
    logic signed [7:0]  rssi_s;
    logic signed [7:0]  wmax;
    logic [31:0]        since_rep;
    logic [31:0]        silent;
    logic signed [9:0]  v_x;
    logic signed [9:0]  up_x;
    logic signed [9:0]  dn_x;
    logic signed [9:0]  td_x;
    rpht_pkg::t_trend   trend;

    assign o_q_pop     = i_q_valid && (!r_rpt_valid || i_rpt_ready);
    assign o_rpt_valid = r_rpt_valid;
    assign o_rpt       = r_rpt;

    always_comb begin
        n_peak        = r_peak;
        n_shown       = r_shown;
        n_window      = r_window;
        n_count       = r_count;
        n_last_report = r_last_report;
        n_last_seen   = r_last_seen;
        fire          = 1'b0;
        trend         = rpht_pkg::TREND_NONE;

        rssi_s    = $signed(i_q_item.rssi);
        since_rep = i_q_item.now_ms - r_last_report;
        silent    = i_q_item.now_ms - r_last_seen;
        wmax      = (rssi_s > r_window) ? rssi_s : r_window;
        v_x       = {{2{wmax[7]}}, wmax};
        td_x      = {4'b0, i_cfg.trend_db};
        up_x      = $signed({{2{r_shown[7]}}, r_shown}) + td_x;
        dn_x      = $signed({{2{r_shown[7]}}, r_shown}) - td_x;

        n_rpt.kind   = rpht_pkg::KIND_DROPOUT;
        n_rpt.shown  = '0;
        n_rpt.peak   = r_peak;
        n_rpt.trend  = rpht_pkg::TREND_NONE;
        n_rpt.count  = r_count;
        n_rpt.silent = silent;

        if (i_q_item.op == rpht_pkg::OP_TICK) begin
            fire = (silent > {16'b0, i_cfg.dropout_ms})
                && (since_rep > {16'b0, i_cfg.dropout_repeat_ms});
            if (fire) begin
                n_last_report = i_q_item.now_ms;
            end
        end else begin
            n_last_seen = i_q_item.now_ms;
            n_window    = wmax;
            fire        = (since_rep >= {16'b0, i_cfg.report_interval_ms});
            if (fire) begin
                n_count = r_count + 1'b1;
                n_peak  = (wmax > r_peak) ? wmax : r_peak;
                if (r_shown != $signed(rpht_pkg::LEVEL_NONE)) begin
                    if (v_x >= up_x) begin
                        trend = rpht_pkg::TREND_CLOSER;
                    end else if (v_x <= dn_x) begin
                        trend = rpht_pkg::TREND_FARTHER;
                    end
                end
                n_shown       = wmax;
                n_window      = $signed(rpht_pkg::LEVEL_NONE);
                n_last_report = i_q_item.now_ms;
            end
            n_rpt.kind   = rpht_pkg::KIND_SIGNAL;
            n_rpt.shown  = wmax;
            n_rpt.peak   = n_peak;
            n_rpt.trend  = trend;
            n_rpt.count  = n_count;
            n_rpt.silent = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && fire) begin
            r_rpt <= n_rpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak        <= $signed(rpht_pkg::LEVEL_NONE);
            r_shown       <= $signed(rpht_pkg::LEVEL_NONE);
            r_window      <= $signed(rpht_pkg::LEVEL_NONE);
            r_count       <= '0;
            r_last_report <= '0;
            r_last_seen   <= '0;
            r_rpt_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_peak        <= n_peak;
                r_shown       <= n_shown;
                r_window      <= n_window;
                r_count       <= n_count;
                r_last_report <= n_last_report;
                r_last_seen   <= n_last_seen;
                r_rpt_valid   <= fire;
            end else if (i_rpt_ready) begin
                r_rpt_valid   <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/rpht_report.sv @@
module rpht_report (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rpt_valid,
    input  rpht_pkg::t_rpt                i_rpt,
    output logic                          o_rpt_ready,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rpht_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [0:0]                    o_m_tuser
);

    logic [rpht_pkg::PROD_W-1:0]   prod;
    logic [rpht_pkg::SILENT_W-1:0] secs;
    logic [rpht_pkg::BAR_W-1:0]    bar;
    logic                          r_valid;
    logic [rpht_pkg::M_DATA_W-1:0] r_data;
    logic                          r_kind;

    assign prod = {29'b0, i_rpt.silent} * {32'b0, rpht_pkg::DIV1000_MUL};
    assign secs = prod[rpht_pkg::DIV1000_SHIFT +: rpht_pkg::SILENT_W];
    assign bar  = (i_rpt.kind == rpht_pkg::KIND_DROPOUT) ? '0 : rpht_pkg::BAR_LUT[i_rpt.shown];

    assign o_rpt_ready = !r_valid || i_m_tready;
    assign o_m_tvalid  = r_valid;
    assign o_m_tdata   = r_data;
    assign o_m_tuser   = r_kind;

    always_ff @(posedge i_clk) begin
        if (i_rpt_valid && o_rpt_ready) begin
            r_data <= {6'b0, secs, i_rpt.count, bar, i_rpt.trend, i_rpt.peak, i_rpt.shown};
            r_kind <= i_rpt.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rpt_ready) begin
            r_valid <= i_rpt_valid;
        end
    end

endmodule

@@ rtl/core/rssi_peak_hold_tracker_core.sv @@
// A result is offered once its input transfer has passed the queue, state-update and output
// registers. Throughput: one input transfer per cycle while the output is not stalled, through a
// two-entry queue between classifier and state-update stage; all tracker state updates on each pop.
// Reset: synchronous, active low; clears the queue, pipeline valids and tracker state and
// loads the configuration defaults. No clearing pass; input ready is low while reset is
// held and high from the cycle reset is released.
module rssi_peak_hold_tracker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [47:0] device_address, [55:48] rssi, [87:56] now_ms
    input  logic [rpht_pkg::S_DATA_W-1:0]   i_s_tdata,
    // [0] op
    input  logic [0:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] shown_rssi, [15:8] peak_rssi, [17:16] trend, [26:18] bar_eighths,
    // [58:27] reading_count, [81:59] silent_seconds, [87:82] zero
    output logic [rpht_pkg::M_DATA_W-1:0]   o_m_tdata,
    // [0] kind
    output logic [0:0]                      o_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [rpht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpht_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    rpht_pkg::t_cfg   r_cfg;
    logic             q_full;
    logic             q_push;
    rpht_pkg::t_qitem q_in;
    logic             q_pop;
    logic             q_valid;
    rpht_pkg::t_qitem q_out;
    logic             rpt_valid;
    logic             rpt_ready;
    rpht_pkg::t_rpt   rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rpht_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpht_pkg::CFG_HUNT_ENABLE:    r_cfg.hunt_enable        <= i_cfg_wdata[0];
                rpht_pkg::CFG_TARGET_ADDRESS: r_cfg.target_address     <= i_cfg_wdata[47:0];
                rpht_pkg::CFG_REPORT_INTV:    r_cfg.report_interval_ms <= i_cfg_wdata[15:0];
                rpht_pkg::CFG_DROPOUT:        r_cfg.dropout_ms         <= i_cfg_wdata[15:0];
                rpht_pkg::CFG_DROPOUT_REPEAT: r_cfg.dropout_repeat_ms  <= i_cfg_wdata[15:0];
                rpht_pkg::CFG_TREND_DB:       r_cfg.trend_db           <= i_cfg_wdata[5:0];
                default:                      r_cfg                    <= r_cfg;
            endcase
        end
    end

    rpht_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (q_push),
        .o_item     (q_in)
    );

    rpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    rpht_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out),
        .o_q_pop     (q_pop),
        .i_rpt_ready (rpt_ready),
        .o_rpt_valid (rpt_valid),
        .o_rpt       (rpt)
    );

    rpht_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rpt_valid (rpt_valid),
        .i_rpt       (rpt),
        .o_rpt_ready (rpt_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

@@ rtl/core/rpht_checker.sv @@
module rpht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [rpht_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [0:0]                    o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // dropout report carries no level, trend or bar
    a_dropout_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata[7:0] == 8'd0 && o_m_tdata[17:16] == 2'd0 && o_m_tdata[26:18] == 9'd0)
        else $error("dropout report with nonzero signal fields");

    // signal report has no silent time, a legal trend and bar within the span
    a_signal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |->
            o_m_tdata[81:59] == 23'd0 && o_m_tdata[17:16] != 2'd3
            && o_m_tdata[26:18] <= rpht_pkg::BAR_FULL)
        else $error("signal report field out of range");

    // a dropout report that directly follows an accepted signal report repeats its reading count
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tuser[0] ##1 o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata[58:27] == $past(o_m_tdata[58:27]))
        else $error("dropout count differs from preceding report");

endmodule

bind rssi_peak_hold_tracker_core rpht_checker u_rpht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
